FILE: rtl/core/lh_pkg.sv
// Package for the log2 latency histogram: codes, controller/datapath
// command and status structs, percentile and unit-scale tables.
// No dependencies.
`default_nettype none
package lh_pkg;

	localparam int NUM_BUCKETS = 64;
	localparam int BKT_W       = 6;
	localparam int NUM_PCT     = 10;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEC, ST_REC_MUL, ST_REC_RD, ST_REC_UPD,
		ST_RANK_MUL, ST_RANK_DIV, ST_SCAN_RD, ST_SCAN_CHK,
		ST_INT_MUL, ST_INT_DIV, ST_CLAMP, ST_BKT_DATA, ST_DONE
	} state_t;

	// operand source for the shared multiplier
	typedef enum logic [1:0] {
		MS_SCALE, MS_RANK, MS_INTERP
	} mul_src_t;

	// bucket memory read address source
	typedef enum logic [1:0] {
		RD_REQ, RD_SCAN, RD_REC
	} rd_src_t;

	// result register update
	typedef enum logic [2:0] {
		RES_HOLD, RES_FAIL, RES_CLEAR, RES_BUCKET,
		RES_MAX, RES_LOWER, RES_INTERP, RES_CLAMP
	} res_src_t;

	typedef struct packed {
		logic     latch_in;
		logic     mul_start;
		mul_src_t mul_src;
		logic     mul_step;
		logic     div_start;
		logic     div_step;
		logic     mem_rd;
		rd_src_t  rd_src;
		logic     rec_prep;
		logic     rec_commit;
		logic     rank_latch;
		logic     scan_clr;
		logic     scan_next;
		logic     hit_latch;
		logic     clear_all;
		res_src_t res_src;
		logic     out_load;
	} ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic sel_bad;
		logic count_zero;
		logic mul_done;
		logic div_done;
		logic hit;
		logic rank_le_prev;
		logic last_idx;
	} stat_t;

	function automatic logic [19:0] pct_num(input logic [3:0] sel);
		logic [19:0] n;
		case (sel)
			4'd0:    n = 20'd1;
			4'd1:    n = 20'd3;
			4'd2:    n = 20'd90;
			4'd3:    n = 20'd95;
			4'd4:    n = 20'd99;
			4'd5:    n = 20'd995;
			4'd6:    n = 20'd999;
			4'd7:    n = 20'd9999;
			4'd8:    n = 20'd99999;
			4'd9:    n = 20'd999999;
			default: n = 20'd0;
		endcase
		return n;
	endfunction

	function automatic logic [19:0] pct_den(input logic [3:0] sel);
		logic [19:0] d;
		case (sel)
			4'd0:    d = 20'd2;
			4'd1:    d = 20'd4;
			4'd2, 4'd3, 4'd4: d = 20'd100;
			4'd5, 4'd6: d = 20'd1000;
			4'd7:    d = 20'd10000;
			4'd8:    d = 20'd100000;
			4'd9:    d = 20'd1000000;
			default: d = 20'd1;
		endcase
		return d;
	endfunction

	function automatic logic [29:0] unit_scale(input logic [1:0] unit);
		logic [29:0] s;
		case (unit)
			2'd0:    s = 30'd1;
			2'd1:    s = 30'd1000;
			2'd2:    s = 30'd1000000;
			default: s = 30'd1000000000;
		endcase
		return s;
	endfunction

	// position of the highest set bit; 0 and 1 both map to 0
	function automatic logic [BKT_W-1:0] floor_log2(input logic [63:0] v);
		logic [BKT_W-1:0] n;
		n = '0;
		for (int i = 1; i < 64; i++) begin
			if (v[i]) n = BKT_W'(i);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lh_if.sv
// Request and response channel interfaces for the latency histogram.
// Depends on nothing.
`default_nettype none
interface lh_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] time_value;
	logic [1:0]  time_unit;
	logic [3:0]  percentile_select;
	logic [5:0]  read_bucket;
	modport source (output valid, command, time_value, time_unit, percentile_select,
		read_bucket, input ready);
	modport sink (input valid, command, time_value, time_unit, percentile_select,
		read_bucket, output ready);
endinterface

interface lh_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [63:0] result_value;
	logic [63:0] num_events;
	logic [63:0] time_total;
	logic [63:0] min_time;
	logic [63:0] max_time;
	logic        overflowed;
	modport source (output valid, ok, result_value, num_events, time_total, min_time,
		max_time, overflowed, input ready);
	modport sink (input valid, ok, result_value, num_events, time_total, min_time,
		max_time, overflowed, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lh_ctrl.sv
// Controller state machine of the latency histogram.
// Depends on lh_pkg.
`default_nettype none
module lh_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire lh_pkg::stat_t stat,
	output lh_pkg::ctrl_t      ctrl
);
	import lh_pkg::*;

	state_t state_q, state_d;
	logic   ovalid_q;
	logic   load;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign load      = (state_q == ST_DONE) && (!ovalid_q || out_ready);

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		ctrl.mul_src = MS_SCALE;
		ctrl.rd_src  = RD_REQ;
		ctrl.res_src = RES_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.latch_in = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				case (stat.cmd)
					CMD_RECORD: begin
						ctrl.mul_start = 1'b1;
						ctrl.mul_src = MS_SCALE;
						state_d = ST_REC_MUL;
					end
					CMD_QUERY: begin
						if (stat.sel_bad || stat.count_zero) begin
							ctrl.res_src = RES_FAIL;
							state_d = ST_DONE;
						end else begin
							ctrl.mul_start = 1'b1;
							ctrl.mul_src = MS_RANK;
							state_d = ST_RANK_MUL;
						end
					end
					CMD_READ: begin
						ctrl.mem_rd = 1'b1;
						ctrl.rd_src = RD_REQ;
						state_d = ST_BKT_DATA;
					end
					default: begin
						ctrl.clear_all = 1'b1;
						ctrl.res_src = RES_CLEAR;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_REC_MUL: begin
				if (stat.mul_done) begin
					ctrl.rec_prep = 1'b1;
					state_d = ST_REC_RD;
				end else begin
					ctrl.mul_step = 1'b1;
				end
			end
			ST_REC_RD: begin
				ctrl.mem_rd = 1'b1;
				ctrl.rd_src = RD_REC;
				state_d = ST_REC_UPD;
			end
			ST_REC_UPD: begin
				ctrl.rec_commit = 1'b1;
				state_d = ST_DONE;
			end
			ST_RANK_MUL: begin
				if (stat.mul_done) begin
					ctrl.div_start = 1'b1;
					state_d = ST_RANK_DIV;
				end else begin
					ctrl.mul_step = 1'b1;
				end
			end
			ST_RANK_DIV: begin
				if (stat.div_done) begin
					ctrl.rank_latch = 1'b1;
					ctrl.scan_clr = 1'b1;
					state_d = ST_SCAN_RD;
				end else begin
					ctrl.div_step = 1'b1;
				end
			end
			ST_SCAN_RD: begin
				ctrl.mem_rd = 1'b1;
				ctrl.rd_src = RD_SCAN;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (stat.hit) begin
					ctrl.hit_latch = 1'b1;
					if (stat.rank_le_prev) begin
						ctrl.res_src = RES_LOWER;
						state_d = ST_CLAMP;
					end else begin
						ctrl.mul_start = 1'b1;
						ctrl.mul_src = MS_INTERP;
						state_d = ST_INT_MUL;
					end
				end else if (stat.last_idx) begin
					ctrl.res_src = RES_MAX;
					state_d = ST_DONE;
				end else begin
					ctrl.scan_next = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_INT_MUL: begin
				if (stat.mul_done) begin
					ctrl.div_start = 1'b1;
					state_d = ST_INT_DIV;
				end else begin
					ctrl.mul_step = 1'b1;
				end
			end
			ST_INT_DIV: begin
				if (stat.div_done) begin
					ctrl.res_src = RES_INTERP;
					state_d = ST_CLAMP;
				end else begin
					ctrl.div_step = 1'b1;
				end
			end
			ST_CLAMP: begin
				ctrl.res_src = RES_CLAMP;
				state_d = ST_DONE;
			end
			ST_BKT_DATA: begin
				ctrl.res_src = RES_BUCKET;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load) begin
					ctrl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/lh_dp.sv
// Datapath of the latency histogram: bucket memory, statistics registers,
// shared 32x32 partial-product multiplier and bit-serial divider.
// Depends on lh_pkg.
`default_nettype none
module lh_dp #(
	parameter int COUNTER_WIDTH = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lh_pkg::ctrl_t ctrl,
	output lh_pkg::stat_t      stat,
	input  wire logic [1:0]    command,
	input  wire logic [63:0]   time_value,
	input  wire logic [1:0]    time_unit,
	input  wire logic [3:0]    percentile_select,
	input  wire logic [5:0]    read_bucket,
	output logic               ok,
	output logic [63:0]        result_value,
	output logic [63:0]        num_events,
	output logic [63:0]        time_total,
	output logic [63:0]        min_time,
	output logic [63:0]        max_time,
	output logic               overflowed
);
	import lh_pkg::*;

	// latched request
	cmd_t             cmd_q;
	logic [63:0]      tval_q;
	logic [1:0]       tunit_q;
	logic [3:0]       psel_q;
	logic [BKT_W-1:0] bidx_q;

	// statistics
	logic [63:0] cnt_q, sum_q, least_q, greatest_q;
	logic        flag_q;

	// bucket memory with per-entry valid bits
	logic [COUNTER_WIDTH-1:0] mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0]   vld_q;
	logic [COUNTER_WIDTH-1:0] rdata_q;
	logic                     rvld_q;
	logic [BKT_W-1:0]         raddr;
	logic                     we;
	logic [COUNTER_WIDTH-1:0] c_cw, wdata;
	logic [63:0]              c64;

	// multiplier
	logic [63:0]  a_q, b_q;
	logic [63:0]  pp_q;
	logic [127:0] prod_q;
	logic [2:0]   k_q;
	logic [2:0]   kk;
	logic [31:0]  a_half, b_half;
	logic [127:0] pp_sh;

	// divider
	logic [127:0] dd_q;
	logic [63:0]  rem_q, q_q, d_q;
	logic [7:0]   n_q;
	logic [63:0]  r2;
	logic         top;
	logic         sub;

	// record and scan working registers
	logic [63:0]      ns_q;
	logic             sovf_q;
	logic [BKT_W-1:0] bkt_q;
	logic [63:0]      rank_q, acc_q, lower_q;
	logic [BKT_W-1:0] idx_q;
	logic [63:0]      acc_new, lower_c, width_c;

	// result
	logic        ok_q;
	logic [63:0] res_q;

	// stored answer
	logic        o_ok_q, o_flag_q;
	logic [63:0] o_res_q, o_cnt_q, o_sum_q, o_min_q, o_max_q;

	// status
	assign c_cw    = rvld_q ? rdata_q : '0;
	assign c64     = 64'(c_cw);
	assign wdata   = c_cw + {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
	assign acc_new = acc_q + c64;

	assign stat.cmd          = cmd_q;
	assign stat.sel_bad      = (psel_q >= 4'(NUM_PCT));
	assign stat.count_zero   = (cnt_q == '0);
	assign stat.mul_done     = (k_q == 3'd5);
	assign stat.div_done     = n_q[7];
	assign stat.hit          = (c64 != '0) && (acc_new >= rank_q);
	assign stat.rank_le_prev = (rank_q <= acc_q);
	assign stat.last_idx     = (idx_q == BKT_W'(NUM_BUCKETS - 1));

	// bucket bounds at the scan position
	always_comb begin
		if (idx_q == '0) begin
			lower_c = '0;
			width_c = 64'd1;
		end else begin
			lower_c = 64'd1 << idx_q;
			width_c = (idx_q == BKT_W'(NUM_BUCKETS - 1)) ? ~lower_c : lower_c - 64'd1;
		end
	end

	// read address select
	always_comb begin
		case (ctrl.rd_src)
			RD_SCAN: raddr = idx_q;
			RD_REC:  raddr = bkt_q;
			default: raddr = bidx_q;
		endcase
	end

	// record is taken only when every check passes
	assign we = ctrl.rec_commit && !sovf_q && !(rvld_q && (rdata_q == '1))
		&& (cnt_q != '1) && !flag_q && !(ns_q > ~sum_q);

	// memory array
	always_ff @(posedge clk) begin
		if (we) mem[bkt_q] <= wdata;
		if (ctrl.mem_rd) rdata_q <= mem[raddr];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctrl.clear_all) vld_q <= '0;
			else if (we) vld_q[bkt_q] <= 1'b1;
			if (ctrl.mem_rd) rvld_q <= vld_q[raddr];
		end
	end

	// statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			least_q    <= '0;
			greatest_q <= '0;
			flag_q     <= 1'b0;
		end else if (ctrl.clear_all) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			least_q    <= '0;
			greatest_q <= '0;
			flag_q     <= 1'b0;
		end else if (ctrl.rec_commit) begin
			if (we) begin
				sum_q <= sum_q + ns_q;
				cnt_q <= cnt_q + 64'd1;
				if (cnt_q == '0) begin
					least_q    <= ns_q;
					greatest_q <= ns_q;
				end else begin
					if (ns_q < least_q) least_q <= ns_q;
					if (ns_q > greatest_q) greatest_q <= ns_q;
				end
			end else if (sovf_q || (rvld_q && (rdata_q == '1)) || (cnt_q == '1)
					|| (!flag_q && (ns_q > ~sum_q))) begin
				flag_q <= 1'b1;
			end
		end
	end

	// partial product select: step kk uses halves kk[0] of a and kk[1] of b
	assign kk     = k_q - 3'd1;
	assign a_half = k_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_half = k_q[1] ? b_q[63:32] : b_q[31:0];
	always_comb begin
		case ({1'b0, kk[0]} + {1'b0, kk[1]})
			2'd0:    pp_sh = {64'd0, pp_q};
			2'd1:    pp_sh = {32'd0, pp_q, 32'd0};
			default: pp_sh = {pp_q, 64'd0};
		endcase
	end

	// divider step
	assign top = rem_q[63];
	assign r2  = {rem_q[62:0], dd_q[127]};
	assign sub = top || (r2 >= d_q);

	// control-path counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			n_q <= '0;
		end else begin
			if (ctrl.mul_start) k_q <= '0;
			else if (ctrl.mul_step) k_q <= k_q + 3'd1;
			if (ctrl.div_start) n_q <= '0;
			else if (ctrl.div_step) n_q <= n_q + 8'd1;
		end
	end

	// request latch, arithmetic units, scan and result
	always_ff @(posedge clk) begin
		if (ctrl.latch_in) begin
			cmd_q   <= cmd_t'(command);
			tval_q  <= time_value;
			tunit_q <= time_unit;
			psel_q  <= percentile_select;
			bidx_q  <= read_bucket;
		end

		// multiplier operands and accumulation
		if (ctrl.mul_start) begin
			prod_q <= '0;
			case (ctrl.mul_src)
				MS_RANK: begin
					a_q <= cnt_q;
					b_q <= 64'(pct_num(psel_q));
					d_q <= 64'(pct_den(psel_q));
				end
				MS_INTERP: begin
					a_q <= width_c;
					b_q <= rank_q - acc_q;
					d_q <= c64;
				end
				default: begin
					a_q <= tval_q;
					b_q <= 64'(unit_scale(tunit_q));
				end
			endcase
		end else if (ctrl.mul_step) begin
			if (k_q < 3'd4) pp_q <= a_half * b_half;
			if (k_q != 3'd0) prod_q <= prod_q + pp_sh;
		end

		// restoring division of the 128-bit product
		if (ctrl.div_start) begin
			dd_q  <= prod_q;
			rem_q <= '0;
			q_q   <= '0;
		end else if (ctrl.div_step) begin
			dd_q  <= {dd_q[126:0], 1'b0};
			rem_q <= sub ? r2 - d_q : r2;
			q_q   <= {q_q[62:0], sub};
		end

		if (ctrl.rec_prep) begin
			ns_q   <= prod_q[63:0];
			sovf_q <= |prod_q[127:64];
			bkt_q  <= floor_log2(prod_q[63:0]);
		end

		if (ctrl.rank_latch) rank_q <= q_q;
		if (ctrl.scan_clr) begin
			acc_q <= '0;
			idx_q <= '0;
		end else if (ctrl.scan_next) begin
			acc_q <= acc_new;
			idx_q <= idx_q + 1'b1;
		end
		if (ctrl.hit_latch) lower_q <= lower_c;

		if (ctrl.rec_commit) begin
			ok_q  <= we;
			res_q <= '0;
		end else begin
			case (ctrl.res_src)
				RES_FAIL: begin
					ok_q  <= 1'b0;
					res_q <= '0;
				end
				RES_CLEAR: begin
					ok_q  <= 1'b1;
					res_q <= '0;
				end
				RES_BUCKET: begin
					ok_q  <= 1'b1;
					res_q <= c64;
				end
				RES_MAX: begin
					ok_q  <= 1'b1;
					res_q <= greatest_q;
				end
				RES_LOWER: begin
					ok_q  <= 1'b1;
					res_q <= lower_c;
				end
				RES_INTERP: begin
					ok_q  <= 1'b1;
					res_q <= lower_q + q_q;
				end
				RES_CLAMP: begin
					if (res_q < least_q) res_q <= least_q;
					else if (res_q > greatest_q) res_q <= greatest_q;
				end
				default: ;
			endcase
		end

		if (ctrl.out_load) begin
			o_ok_q   <= ok_q;
			o_res_q  <= res_q;
			o_cnt_q  <= cnt_q;
			o_sum_q  <= sum_q;
			o_min_q  <= least_q;
			o_max_q  <= greatest_q;
			o_flag_q <= flag_q;
		end
	end

	assign ok           = o_ok_q;
	assign result_value = o_res_q;
	assign num_events   = o_cnt_q;
	assign time_total   = o_sum_q;
	assign min_time     = o_min_q;
	assign max_time     = o_max_q;
	assign overflowed   = o_flag_q;

endmodule
`default_nettype wire

FILE: rtl/core/log2_latency_histogram_unit.sv
// Latency histogram with floor-log2 buckets; one request at a time, the next taken after the response loads.
// Record: unit scaling in a 5-step 32x32 multiplier, then a bucket read and the counter update.
// Read bucket: one memory read. Clear or refused query: no arithmetic. Query: set by up to two
// 128-step bit-serial divisions and a memory scan that checks one bucket at a time. A held response stalls.
// Reset (arst_n low) clears all statistics, the bucket valid bits and the flag.
// Depends on lh_pkg, lh_if, lh_ctrl, lh_dp.
`default_nettype none
module log2_latency_histogram_unit #(
	parameter int COUNTER_WIDTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	lh_req_if.sink   req,
	lh_rsp_if.source rsp
);
	import lh_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	lh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	lh_dp #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.stat              (stat),
		.command           (req.command),
		.time_value        (req.time_value),
		.time_unit         (req.time_unit),
		.percentile_select (req.percentile_select),
		.read_bucket       (req.read_bucket),
		.ok                (rsp.ok),
		.result_value      (rsp.result_value),
		.num_events        (rsp.num_events),
		.time_total        (rsp.time_total),
		.min_time          (rsp.min_time),
		.max_time          (rsp.max_time),
		.overflowed        (rsp.overflowed)
	);

	// busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("accepted a request while busy");

	// empty histogram reports zero bounds
	a_empty_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.num_events == 64'd0 |-> rsp.min_time == 64'd0
			&& rsp.max_time == 64'd0 && rsp.time_total == 64'd0)
		else $error("nonzero bounds with no events");

	// bounds are ordered once events exist
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.num_events != 64'd0 |-> rsp.min_time <= rsp.max_time)
		else $error("min above max");

endmodule
`default_nettype wire
